// ===== rtl/ohl_pkg.sv =====
// ----------------------------------------------------------------------------
// ohl_pkg
// Shared types and codes for the ordered handle list: operation and status
// codes, and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ohl_pkg;

	localparam int HANDLE_W = 32;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND  = 2'd0,
		OP_REMOVE  = 2'd1,
		OP_POP     = 2'd2,
		OP_REVERSE = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_ZERO  = 2'd3
	} st_t;

	typedef struct packed {
		logic take;
		logic exec;
		logic append;
		logic pop;
		logic pop_read;
		logic pop_fill;
		logic rev;
		logic walk_start;
		logic walk;
		logic walk_end;
		logic load_out;
		st_t  code;
	} ohl_cmd_t;

	typedef struct packed {
		op_t  op;
		logic key_zero;
		logic empty;
		logic single;
		logic full;
		logic walk_done;
	} ohl_sts_t;

endpackage

`default_nettype wire

// ===== rtl/ohl_ram.sv =====
// ----------------------------------------------------------------------------
// ohl_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ohl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                     clk,
	input  wire logic                                     wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                         wr_data,
	input  wire logic                                     rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ohl_ctrl.sv =====
// ----------------------------------------------------------------------------
// ohl_ctrl
// Sequencer for the handle list: takes one beat, decides the operation,
// runs the remove walk or the pop refill, then hands the result to the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ohl_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	input  wire ohl_pkg::ohl_sts_t sts,
	output ohl_pkg::ohl_cmd_t      cmd
);

	import ohl_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_EXEC  = 5'b00010,
		S_POPRD = 5'b00100,
		S_WALK  = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign out_valid = out_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_stall = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				cmd.code = ST_OK;
				state_d  = S_DONE;
				case (sts.op)
					OP_APPEND: begin
						if (sts.key_zero) begin
							cmd.code = ST_ZERO;
						end else if (sts.full) begin
							cmd.code = ST_FULL;
						end else begin
							cmd.append = 1'b1;
						end
					end
					OP_REMOVE: begin
						if (sts.key_zero) begin
							cmd.code = ST_ZERO;
						end else begin
							cmd.walk_start = 1'b1;
							state_d        = S_WALK;
						end
					end
					OP_POP: begin
						if (sts.empty) begin
							cmd.code = ST_EMPTY;
						end else begin
							cmd.pop = 1'b1;
							// more than one entry: fetch the new front
							if (!sts.single) begin
								cmd.pop_read = 1'b1;
								state_d      = S_POPRD;
							end
						end
					end
					OP_REVERSE: begin
						cmd.rev = 1'b1;
					end
					default: begin
						cmd.code = ST_OK;
					end
				endcase
			end
			S_POPRD: begin
				cmd.pop_fill = 1'b1;
				state_d      = S_DONE;
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (sts.walk_done) begin
					cmd.walk_end = 1'b1;
					state_d      = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ohl_dp.sv =====
// ----------------------------------------------------------------------------
// ohl_dp
// Datapath of the handle list: entries sit in a circular buffer with a base
// pointer, a count and a direction flag; front and back are kept in registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ohl_dp #(
	parameter int LIST_DEPTH = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire ohl_pkg::ohl_cmd_t                  cmd,
	output ohl_pkg::ohl_sts_t                       sts,
	input  wire logic [ohl_pkg::OP_W-1:0]           op,
	input  wire logic [ohl_pkg::HANDLE_W-1:0]       handle,
	output logic      [ohl_pkg::STATUS_W-1:0]       status,
	output logic      [ohl_pkg::HANDLE_W-1:0]       popped_handle,
	output logic      [ohl_pkg::COUNT_W-1:0]        removed_count,
	output logic      [ohl_pkg::COUNT_W-1:0]        entry_count,
	output logic      [ohl_pkg::HANDLE_W-1:0]       front_handle,
	output logic      [ohl_pkg::HANDLE_W-1:0]       back_handle
);

	import ohl_pkg::*;

	localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int XW = CW + COUNT_W;

	// base plus offset, modulo the depth; the sum stays below twice the depth
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
		input logic [CW-1:0] ofs);
		logic [SW-1:0] s;
		s = SW'(base) + SW'(ofs);
		if (s >= SW'(LIST_DEPTH)) begin
			s = s - SW'(LIST_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	op_t                 op_q;
	logic [HANDLE_W-1:0] key_q;
	logic [AW-1:0]       lo_q;
	logic [CW-1:0]       cnt_q;
	logic                rev_q;
	logic [HANDLE_W-1:0] front_q;
	logic [HANDLE_W-1:0] back_q;
	st_t                 st_q;
	logic [HANDLE_W-1:0] popped_q;
	logic [CW-1:0]       removed_q;
	logic [CW-1:0]       rd_i_q;
	logic [CW-1:0]       w_q;
	logic                rd_vld_s1;
	logic [HANDLE_W-1:0] first_q;
	logic [HANDLE_W-1:0] last_q;

	logic [STATUS_W-1:0] res_status_q;
	logic [HANDLE_W-1:0] res_popped_q;
	logic [COUNT_W-1:0]  res_removed_q;
	logic [COUNT_W-1:0]  res_count_q;
	logic [HANDLE_W-1:0] res_front_q;
	logic [HANDLE_W-1:0] res_back_q;

	logic [AW-1:0]       lo_dec;
	logic [AW-1:0]       app_addr;
	logic [AW-1:0]       nxt_addr;
	logic [AW-1:0]       walk_rd_addr;
	logic [AW-1:0]       walk_wr_addr;
	logic [CW-1:0]       cnt_m2;
	logic                issue;
	logic                hit;
	logic                keep;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [HANDLE_W-1:0] wr_data;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic [HANDLE_W-1:0] rd_data;
	logic [XW-1:0]       cnt_x;
	logic [XW-1:0]       removed_x;

	assign lo_dec       = (lo_q == '0) ? AW'(LIST_DEPTH - 1) : lo_q - 1'b1;
	assign cnt_m2       = cnt_q - CW'(2);
	// reversed lists grow at the low end of the buffer and shrink at the high end
	assign app_addr     = rev_q ? lo_dec : wrap_add(lo_q, cnt_q);
	assign nxt_addr     = rev_q ? wrap_add(lo_q, cnt_m2) : wrap_add(lo_q, CW'(1));
	assign walk_rd_addr = wrap_add(lo_q, rd_i_q);
	assign walk_wr_addr = wrap_add(lo_q, w_q);

	assign issue = cmd.walk && (rd_i_q != cnt_q);
	assign hit   = rd_vld_s1 && (rd_data == key_q);
	assign keep  = rd_vld_s1 && (rd_data != key_q);

	assign wr_en   = cmd.append || keep;
	assign wr_addr = cmd.append ? app_addr : walk_wr_addr;
	assign wr_data = cmd.append ? key_q : rd_data;
	assign rd_en   = cmd.pop_read || issue;
	assign rd_addr = cmd.pop_read ? nxt_addr : walk_rd_addr;

	ohl_ram #(
		.WIDTH (HANDLE_W),
		.DEPTH (LIST_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		sts.op        = op_q;
		sts.key_zero  = (key_q == '0);
		sts.empty     = (cnt_q == '0);
		sts.single    = (cnt_q == CW'(1));
		sts.full      = (cnt_q == CW'(LIST_DEPTH));
		sts.walk_done = (rd_i_q == cnt_q) && !rd_vld_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q      <= '0;
			cnt_q     <= '0;
			rev_q     <= 1'b0;
			front_q   <= '0;
			back_q    <= '0;
			st_q      <= ST_OK;
			popped_q  <= '0;
			removed_q <= '0;
			rd_i_q    <= '0;
			w_q       <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cmd.exec) begin
				st_q      <= cmd.code;
				popped_q  <= cmd.pop ? front_q : '0;
				removed_q <= '0;
			end
			if (cmd.append) begin
				cnt_q  <= cnt_q + 1'b1;
				back_q <= key_q;
				if (rev_q) begin
					lo_q <= lo_dec;
				end
				if (cnt_q == '0) begin
					front_q <= key_q;
				end
			end
			if (cmd.pop) begin
				cnt_q <= cnt_q - 1'b1;
				if (!rev_q) begin
					lo_q <= wrap_add(lo_q, CW'(1));
				end
				if (cnt_q == CW'(1)) begin
					front_q <= '0;
					back_q  <= '0;
				end
			end
			if (cmd.pop_fill) begin
				front_q <= rd_data;
			end
			if (cmd.rev) begin
				rev_q   <= ~rev_q;
				front_q <= back_q;
				back_q  <= front_q;
			end
			if (cmd.walk_start) begin
				rd_i_q    <= '0;
				w_q       <= '0;
				rd_vld_s1 <= 1'b0;
			end else if (cmd.walk) begin
				rd_vld_s1 <= issue;
				if (issue) begin
					rd_i_q <= rd_i_q + 1'b1;
				end
				if (keep) begin
					w_q <= w_q + 1'b1;
				end
				if (hit) begin
					removed_q <= removed_q + 1'b1;
				end
			end
			// survivors are packed from the base upward, order kept
			if (cmd.walk_end) begin
				cnt_q <= w_q;
				if (w_q == '0) begin
					front_q <= '0;
					back_q  <= '0;
				end else begin
					front_q <= rev_q ? last_q : first_q;
					back_q  <= rev_q ? first_q : last_q;
				end
			end
		end
	end

	assign cnt_x     = XW'(cnt_q);
	assign removed_x = XW'(removed_q);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q  <= op_t'(op);
			key_q <= handle;
		end
		if (cmd.walk && keep) begin
			if (w_q == '0) begin
				first_q <= rd_data;
			end
			last_q <= rd_data;
		end
		if (cmd.load_out) begin
			res_status_q  <= st_q;
			res_popped_q  <= popped_q;
			res_removed_q <= removed_x[COUNT_W-1:0];
			res_count_q   <= cnt_x[COUNT_W-1:0];
			res_front_q   <= front_q;
			res_back_q    <= back_q;
		end
	end

	assign status        = res_status_q;
	assign popped_handle = res_popped_q;
	assign removed_count = res_removed_q;
	assign entry_count   = res_count_q;
	assign front_handle  = res_front_q;
	assign back_handle   = res_back_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(LIST_DEPTH))
		else $error("entry count above list depth");

	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (front_q == '0) && (back_q == '0))
		else $error("empty list holds a front or back entry");

	a_walk_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk |-> (w_q <= rd_i_q))
		else $error("walk write index passed read index");

	a_pop_refill: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_read |=> cmd.pop_fill && (cnt_q != '0))
		else $error("pop refill out of sequence");
`endif

endmodule

`default_nettype wire

// ===== rtl/ordered_handle_list_core.sv =====
// ----------------------------------------------------------------------------
// ordered_handle_list_core
// Bounded ordered list of nonzero 32-bit handles with append, remove-all,
// pop-front and reverse. Takes one beat at a time and returns one result
// beat per input beat. Pop with more than one entry reads the new front
// from the entry memory; remove walks the stored entries one per cycle
// through the single read port of the entry memory. Reverse flips a
// direction flag and swaps the front and back registers. A new input beat
// is taken as soon as the previous one has reached the output register,
// even if that result is still stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_handle_list_core #(
	parameter int LIST_DEPTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [ohl_pkg::OP_W-1:0]      op,
	input  wire logic [ohl_pkg::HANDLE_W-1:0]  handle,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [ohl_pkg::STATUS_W-1:0]  status,
	output logic      [ohl_pkg::HANDLE_W-1:0]  popped_handle,
	output logic      [ohl_pkg::COUNT_W-1:0]   removed_count,
	output logic      [ohl_pkg::COUNT_W-1:0]   entry_count,
	output logic      [ohl_pkg::HANDLE_W-1:0]  front_handle,
	output logic      [ohl_pkg::HANDLE_W-1:0]  back_handle
);

	import ohl_pkg::*;

	ohl_cmd_t cmd;
	ohl_sts_t sts;

	ohl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ohl_dp #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.op            (op),
		.handle        (handle),
		.status        (status),
		.popped_handle (popped_handle),
		.removed_count (removed_count),
		.entry_count   (entry_count),
		.front_handle  (front_handle),
		.back_handle   (back_handle)
	);

endmodule

`default_nettype wire

// ===== tb/sv/ohl_list_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohl_list_checker
// Watches both channels of the ordered handle list, keeps its own copy of the
// list, works out the result each input beat must give and compares every
// output beat field by field against the oldest outstanding result.
// ----------------------------------------------------------------------------

module ohl_list_checker #(
	parameter int LIST_DEPTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic                          in_stall,
	input  wire logic [ohl_pkg::OP_W-1:0]      op,
	input  wire logic [ohl_pkg::HANDLE_W-1:0]  handle,
	input  wire logic                          out_valid,
	input  wire logic                          out_stall,
	input  wire logic [ohl_pkg::STATUS_W-1:0]  status,
	input  wire logic [ohl_pkg::HANDLE_W-1:0]  popped_handle,
	input  wire logic [ohl_pkg::COUNT_W-1:0]   removed_count,
	input  wire logic [ohl_pkg::COUNT_W-1:0]   entry_count,
	input  wire logic [ohl_pkg::HANDLE_W-1:0]  front_handle,
	input  wire logic [ohl_pkg::HANDLE_W-1:0]  back_handle,
	output int                                 mismatch_count,
	output int                                 awaiting
);

	import ohl_pkg::*;

	typedef struct packed {
		st_t                 status;
		logic [HANDLE_W-1:0] popped;
		logic [COUNT_W-1:0]  removed;
		logic [COUNT_W-1:0]  count;
		logic [HANDLE_W-1:0] front;
		logic [HANDLE_W-1:0] back;
	} list_result_t;

	logic [HANDLE_W-1:0] held_handles [LIST_DEPTH];
	int                  held_n;
	list_result_t        awaited_results [$];

	// updates the local list copy and returns the result the beat must produce
	function automatic list_result_t apply_list_op(op_t o, logic [HANDLE_W-1:0] h);
		list_result_t        r;
		int                  kept;
		logic [HANDLE_W-1:0] t;
		r = '0;
		r.status = ST_OK;
		case (o)
			OP_APPEND: begin
				if (h == '0) begin
					r.status = ST_ZERO;
				end else if (held_n >= LIST_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					held_handles[held_n] = h;
					held_n++;
				end
			end
			OP_REMOVE: begin
				if (h == '0) begin
					r.status = ST_ZERO;
				end else begin
					kept = 0;
					for (int i = 0; i < held_n; i++) begin
						if (held_handles[i] == h) begin
							r.removed = r.removed + 1'b1;
						end else begin
							held_handles[kept] = held_handles[i];
							kept++;
						end
					end
					held_n = kept;
				end
			end
			OP_POP: begin
				if (held_n == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.popped = held_handles[0];
					for (int i = 1; i < held_n; i++)
						held_handles[i - 1] = held_handles[i];
					held_n--;
				end
			end
			default: begin
				for (int i = 0; i < held_n / 2; i++) begin
					t = held_handles[i];
					held_handles[i] = held_handles[held_n - 1 - i];
					held_handles[held_n - 1 - i] = t;
				end
			end
		endcase
		r.count = COUNT_W'(held_n);
		if (held_n > 0) begin
			r.front = held_handles[0];
			r.back = held_handles[held_n - 1];
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		string        diff;
		list_result_t want;
		if (!arst_n) begin
			held_n = 0;
			awaited_results.delete();
			mismatch_count = 0;
			awaiting = 0;
		end else begin
			// the result leaving now is always older than a beat entering now
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: result beat with nothing outstanding", $realtime);
				end else begin
					want = awaited_results.pop_front();
					diff = "";
					if (status !== want.status)
						diff = {diff, $sformatf(" status %0d/%0d", want.status, status)};
					if (popped_handle !== want.popped)
						diff = {diff, $sformatf(" popped %h/%h", want.popped, popped_handle)};
					if (removed_count !== want.removed)
						diff = {diff, $sformatf(" removed %0d/%0d", want.removed, removed_count)};
					if (entry_count !== want.count)
						diff = {diff, $sformatf(" count %0d/%0d", want.count, entry_count)};
					if (front_handle !== want.front)
						diff = {diff, $sformatf(" front %h/%h", want.front, front_handle)};
					if (back_handle !== want.back)
						diff = {diff, $sformatf(" back %h/%h", want.back, back_handle)};
					if (diff != "") begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%0t: mismatch (expected/actual):%s", $realtime, diff);
					end
				end
			end
			if (in_valid && !in_stall)
				awaited_results.push_back(apply_list_op(op_t'(op), handle));
			awaiting = awaited_results.size();
		end
	end

endmodule

// ===== tb/sv/tb_ordered_handle_list_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_handle_list_core
// Drives directed and random append, remove, pop and reverse beats into the
// ordered handle list with random idle and stall bursts and one long output
// hold, and leaves result checking to the list checker beside the block.
// ----------------------------------------------------------------------------

module tb_ordered_handle_list_core;

	import ohl_pkg::*;

	localparam int LIST_DEPTH   = 16;
	localparam int RANDOM_BEATS = 1120;
	localparam int QUIET_FROM   = 980;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 120;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int POOL_N       = 6;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [OP_W-1:0]      op = '0;
	logic [HANDLE_W-1:0]  handle = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [STATUS_W-1:0]  status;
	logic [HANDLE_W-1:0]  popped_handle;
	logic [COUNT_W-1:0]   removed_count;
	logic [COUNT_W-1:0]   entry_count;
	logic [HANDLE_W-1:0]  front_handle;
	logic [HANDLE_W-1:0]  back_handle;

	int                   fail_total;
	int                   awaiting;
	int                   beats_in = 0;
	int                   cycles = 0;
	bit                   quiet = 1'b0;
	logic [HANDLE_W-1:0]  handle_pool [POOL_N];

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	ordered_handle_list_core #(
		.LIST_DEPTH(LIST_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.handle(handle),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.popped_handle(popped_handle),
		.removed_count(removed_count),
		.entry_count(entry_count),
		.front_handle(front_handle),
		.back_handle(back_handle)
	);

	ohl_list_checker #(
		.LIST_DEPTH(LIST_DEPTH)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.handle(handle),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.popped_handle(popped_handle),
		.removed_count(removed_count),
		.entry_count(entry_count),
		.front_handle(front_handle),
		.back_handle(back_handle),
		.mismatch_count(fail_total),
		.awaiting(awaiting)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// holds the beat until it is taken, then maybe leaves an idle burst
	task automatic send_beat(input op_t o, input logic [HANDLE_W-1:0] h);
		int gap;
		in_valid <= 1'b1;
		op <= o;
		handle <= h;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		beats_in++;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 10);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [HANDLE_W-1:0] fresh_handle();
		logic [HANDLE_W-1:0] v;
		do
			v = $urandom();
		while (v == '0);
		return v;
	endfunction

	// mostly handles from a small pool so removes find matches and repeats
	function automatic logic [HANDLE_W-1:0] pick_handle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 30)
			return $urandom();
		return handle_pool[$urandom_range(0, POOL_N - 1)];
	endfunction

	initial begin : receiver
		int  burst;
		bit  held;
		held = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			@(posedge clk);
			if (!held && beats_in >= HOLD_AT) begin
				// long hold so the block backs up and stalls its input
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(1, 10);
				out_stall <= 1'b1;
				repeat (burst) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		int                  r;
		int                  app_pct;
		int                  pop_lim;
		logic [HANDLE_W-1:0] fill [4];
		fill[0] = 32'hFFFF_FFFF;
		fill[1] = 32'h0000_0002;
		fill[2] = 32'h8000_0000;
		fill[3] = 32'h0000_0002;
		for (int i = 0; i < POOL_N; i++)
			handle_pool[i] = fresh_handle();
		app_pct = 50;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list corners and zero handles
		send_beat(OP_POP, 32'h1234_5678);
		send_beat(OP_REVERSE, '0);
		send_beat(OP_REMOVE, 32'h0000_0009);
		send_beat(OP_APPEND, '0);
		send_beat(OP_REMOVE, '0);
		send_beat(OP_APPEND, 32'h0000_0001);
		send_beat(OP_REVERSE, 32'hFFFF_FFFF);
		// fill to the brim, then overflow
		for (int i = 0; i < LIST_DEPTH - 1; i++)
			send_beat(OP_APPEND, fill[i % 4]);
		send_beat(OP_APPEND, 32'h0000_0003);
		send_beat(OP_REVERSE, '0);
		send_beat(OP_REMOVE, 32'h0000_0002);
		send_beat(OP_POP, '0);
		send_beat(OP_REMOVE, 32'h0001_2345);

		for (int n = 0; n < RANDOM_BEATS; n++) begin
			// shift the mix now and then so the list swings between empty and full
			if (n % 150 == 0) begin
				app_pct = 30 + 15 * $urandom_range(0, 3);
				handle_pool[$urandom_range(0, POOL_N - 1)] = fresh_handle();
			end
			if (n == QUIET_FROM)
				quiet = 1'b1;
			pop_lim = app_pct + 20 + (80 - app_pct) * 2 / 3;
			r = $urandom_range(0, 99);
			if (r < app_pct)
				send_beat(OP_APPEND, pick_handle());
			else if (r < app_pct + 20)
				send_beat(OP_REMOVE, pick_handle());
			else if (r < pop_lim)
				send_beat(OP_POP, $urandom());
			else
				send_beat(OP_REVERSE, $urandom());
		end
		in_valid <= 1'b0;

		wait (awaiting == 0);
		repeat (LIST_DEPTH + 8) @(posedge clk);
		// every beat taken must have come back
		if (fail_total == 0 && awaiting == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
